// ===== rtl/core/thbs_pkg.sv =====
`timescale 1ns / 1ps

package thbs_pkg;

   // Pixel and result field widths.
   localparam int CHAN_W    = 16;
   localparam int NUM_CHAN  = 3;
   localparam int ROW_W     = 12;
   localparam int PIX_COL_W = 10;

   // Configuration register widths and limits.
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int LIMIT_W      = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int MIN_SIZE     = 3;
   localparam int MAX_HEIGHT   = 4096;
   localparam int DEFAULT_MAX_WIDTH = 1024;

   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [LIMIT_W-1:0]      LIMIT_RESET  = 16'd1024;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANGE_LIMIT = 2'd2;

   // A 3x3 sum of 16-bit channels stays below 2^20. Multiplying by
   // ceil(2^23 / 9) and shifting right by 23 gives the exact quotient by
   // nine for every sum below 2^21.
   localparam int SUM_W       = 20;
   localparam int PROD_W      = 2 * SUM_W;
   localparam int RECIP_SHIFT = 23;
   localparam logic [SUM_W-1:0] RECIP_NINE = 20'd932068;

   // Response queue.
   localparam int RSP_DEPTH   = 8;
   localparam int RSP_PTR_W   = $clog2(RSP_DEPTH);
   localparam int RSP_LEVEL_W = RSP_PTR_W + 1;
   localparam int PUSH_W      = 2;
   localparam logic [PUSH_W-1:0] PUSH_TWO = 2'd2;

   // Channel 0 is red, 1 green, 2 blue.
   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_type;

   typedef struct packed {
      logic [ROW_W-1:0]     row;
      logic [PIX_COL_W-1:0] col;
      rgb_type              pix;
      logic                 done;
   } rsp_item_type;

   // Up to two results leave the compute stage per request, first in order.
   typedef struct packed {
      logic [PUSH_W-1:0] count;
      rsp_item_type      first;
      rsp_item_type      second;
   } rsp_push_type;

endpackage

// ===== rtl/core/thbs_line_ram.sv =====
`timescale 1ns / 1ps

module thbs_line_ram #(
   parameter int DEPTH = thbs_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  thbs_pkg::rgb_type        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output thbs_pkg::rgb_type        rd_data
);
   import thbs_pkg::*;

   rgb_type mem_ff [DEPTH];
   rgb_type rd_data_ff;

   // Read-first: a read and a write at the same address return the old entry.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/thbs_smooth.sv =====
`timescale 1ns / 1ps

module thbs_smooth (
   input  thbs_pkg::rgb_type                  tl,
   input  thbs_pkg::rgb_type                  tc,
   input  thbs_pkg::rgb_type                  tr,
   input  thbs_pkg::rgb_type                  ml,
   input  thbs_pkg::rgb_type                  mc,
   input  thbs_pkg::rgb_type                  mr,
   input  thbs_pkg::rgb_type                  bl,
   input  thbs_pkg::rgb_type                  bc,
   input  thbs_pkg::rgb_type                  br,
   input  logic [thbs_pkg::LIMIT_W-1:0]       limit,
   output thbs_pkg::rgb_type                  fin
);
   import thbs_pkg::*;

   logic [SUM_W-1:0]  sum      [NUM_CHAN];
   logic [PROD_W-1:0] prod     [NUM_CHAN];
   logic [CHAN_W-1:0] mean     [NUM_CHAN];
   logic [CHAN_W-1:0] distance [NUM_CHAN];

   always_comb begin
      for (int k = 0; k < NUM_CHAN; k++) begin
         sum[k] = SUM_W'(tl[k]) + SUM_W'(tc[k]) + SUM_W'(tr[k])
                + SUM_W'(ml[k]) + SUM_W'(mc[k]) + SUM_W'(mr[k])
                + SUM_W'(bl[k]) + SUM_W'(bc[k]) + SUM_W'(br[k]);
         prod[k] = PROD_W'(sum[k]) * PROD_W'(RECIP_NINE);
         mean[k] = CHAN_W'(prod[k] >> RECIP_SHIFT);
         distance[k] = (mc[k] > mean[k]) ? (mc[k] - mean[k]) : (mean[k] - mc[k]);
         fin[k]  = (distance[k] > limit) ? mean[k] : mc[k];
      end
   end

endmodule

// ===== rtl/core/thbs_rsp_fifo.sv =====
`timescale 1ns / 1ps

module thbs_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  thbs_pkg::rsp_push_type            push,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output thbs_pkg::rsp_item_type            rsp_item,
   output logic [thbs_pkg::RSP_LEVEL_W-1:0]  level
);
   import thbs_pkg::*;

   rsp_item_type           entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   head_ff, head_in;
   logic [RSP_PTR_W-1:0]   tail_ff, tail_in;
   logic [RSP_PTR_W-1:0]   tail_next;
   logic [RSP_LEVEL_W-1:0] level_ff, level_in;
   logic                   pop;

   assign rsp_valid = (level_ff != '0);
   assign rsp_item  = entry_ff[head_ff];
   assign level     = level_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign tail_next = tail_ff + 1'b1;

   always_comb begin
      head_in  = pop ? (head_ff + 1'b1) : head_ff;
      tail_in  = tail_ff + RSP_PTR_W'(push.count);
      level_in = level_ff + RSP_LEVEL_W'(push.count) - RSP_LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != '0) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.count == PUSH_TWO) begin
         entry_ff[tail_next] <= push.second;
      end
   end

endmodule

// ===== rtl/core/thresholded_box_smoother_core.sv =====
// Path: each request is registered in the compute stage, which writes its results to the
// response queue; an interior pixel is finished when its lower-right neighbor is there.
// Throughput: one pixel per clock while the queue has room and no register is written; the
// last row from column two on and the last column from row two on yield two results each.
// Reset (synchronous): clears position counters, window, pipeline and response queue and
// restores register defaults. The line memories are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module thresholded_box_smoother_core #(
   parameter int MAX_WIDTH = thbs_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [thbs_pkg::CHAN_W-1:0]          req_red_in,
   input  logic [thbs_pkg::CHAN_W-1:0]          req_green_in,
   input  logic [thbs_pkg::CHAN_W-1:0]          req_blue_in,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [thbs_pkg::ROW_W-1:0]           rsp_pixel_row,
   output logic [thbs_pkg::PIX_COL_W-1:0]       rsp_pixel_col,
   output logic [thbs_pkg::CHAN_W-1:0]          rsp_red_out,
   output logic [thbs_pkg::CHAN_W-1:0]          rsp_green_out,
   output logic [thbs_pkg::CHAN_W-1:0]          rsp_blue_out,
   output logic                                 rsp_frame_done,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [thbs_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [thbs_pkg::CSR_DATA_W-1:0]      csr_data
);
   import thbs_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WIN_DEPTH = 6;

   // Configuration registers.
   logic [WIDTH_REG_W-1:0]  frame_width_ff;
   logic [HEIGHT_REG_W-1:0] frame_height_ff;
   logic [LIMIT_W-1:0]      change_limit_ff;

   // Raster position of the next request.
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [COL_W-1:0] col_last, cur_col;
   logic [ROW_W-1:0] row_last, cur_row;
   logic             accept;
   rgb_type          req_pix;

   // Compute stage.
   logic             s1_valid_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [COL_W-1:0] s1_col_ff;
   rgb_type          s1_pix_ff;
   logic             s1_fin_en_ff;
   logic             s1_border_ff;
   logic             s1_done_ff;

   rgb_type win_ff [WIN_DEPTH];
   rgb_type win_in [WIN_DEPTH];

   rgb_type upper_rd, middle_rd, top_pix, fin_pix;

   // Upper line write port, the deferred write and the last committed write.
   logic             up_wr_en;
   logic [COL_W-1:0] up_wr_addr;
   rgb_type          up_wr_data;
   logic             pend_valid_ff, pend_valid_in;
   logic [COL_W-1:0] pend_addr_ff, pend_addr_in;
   rgb_type          pend_data_ff, pend_data_in;
   logic             up_last_en_ff;
   logic [COL_W-1:0] up_last_addr_ff;
   rgb_type          up_last_data_ff;

   rsp_push_type           push;
   rsp_item_type           rsp_item;
   logic [RSP_LEVEL_W-1:0] fifo_level;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         change_limit_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[WIDTH_REG_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[HEIGHT_REG_W-1:0];
            CSR_CHANGE_LIMIT: change_limit_ff <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sizes outside the supported range are clamped.
   always_comb begin
      if (frame_width_ff < WIDTH_REG_W'(MIN_SIZE)) begin
         col_last = COL_W'(MIN_SIZE - 1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         col_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         col_last = COL_W'(frame_width_ff - 1'b1);
      end
      if (frame_height_ff < HEIGHT_REG_W'(MIN_SIZE)) begin
         row_last = ROW_W'(MIN_SIZE - 1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         row_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         row_last = ROW_W'(frame_height_ff - 1'b1);
      end
   end

   // ---------------------------------------------------------------- input
   // Room is kept for two results from the new request and whatever the
   // compute stage pushes now. No request is taken in a cycle with a
   // register write so that the write applies first.
   assign req_ready = ((fifo_level + RSP_LEVEL_W'(push.count))
                       <= RSP_LEVEL_W'(RSP_DEPTH - 2)) && !csr_valid;
   assign accept  = req_valid && req_ready;
   assign req_pix = {req_blue_in, req_green_in, req_red_in};

   assign cur_col = (col_count_ff > col_last) ? col_last : col_count_ff;
   assign cur_row = (row_count_ff > row_last) ? row_last : row_count_ff;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (accept) begin
         if (cur_col == col_last) begin
            col_count_in = '0;
            row_count_in = (cur_row == row_last) ? '0 : (cur_row + 1'b1);
         end else begin
            col_count_in = cur_col + 1'b1;
            row_count_in = cur_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         s1_valid_ff  <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff    <= cur_row;
         s1_col_ff    <= cur_col;
         s1_pix_ff    <= req_pix;
         s1_fin_en_ff <= (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
         s1_border_ff <= (cur_row == '0) || (cur_row == row_last)
                         || (cur_col == '0) || (cur_col == col_last);
         s1_done_ff   <= (cur_row == row_last) && (cur_col == col_last);
      end
   end

   // ---------------------------------------------------------------- lines
   thbs_line_ram #(
      .DEPTH   (MAX_WIDTH)
   ) u_upper (
      .clock   (clock),
      .wr_en   (up_wr_en),
      .wr_addr (up_wr_addr),
      .wr_data (up_wr_data),
      .rd_addr (cur_col),
      .rd_data (upper_rd)
   );

   thbs_line_ram #(
      .DEPTH   (MAX_WIDTH)
   ) u_middle (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (cur_col),
      .wr_data (req_pix),
      .rd_addr (cur_col),
      .rd_data (middle_rd)
   );

   // Each request updates the upper line with the middle line pixel at its own
   // column and, when it finishes a pixel, with that pixel one column to the left. The first
   // is held back one request, where the next finished pixel usually lands
   // on the same column and replaces it.
   always_comb begin
      up_wr_en      = 1'b0;
      up_wr_addr    = pend_addr_ff;
      up_wr_data    = pend_data_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_data_in  = pend_data_ff;
      if (s1_valid_ff) begin
         if (s1_fin_en_ff) begin
            up_wr_en   = 1'b1;
            up_wr_addr = s1_col_ff - 1'b1;
            up_wr_data = fin_pix;
         end else begin
            up_wr_en   = pend_valid_ff;
         end
         pend_valid_in = 1'b1;
         pend_addr_in  = s1_col_ff;
         pend_data_in  = middle_rd;
      end else begin
         up_wr_en = pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         up_last_en_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         up_last_en_ff <= up_wr_en;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff    <= pend_addr_in;
      pend_data_ff    <= pend_data_in;
      up_last_addr_ff <= up_wr_addr;
      up_last_data_ff <= up_wr_data;
   end

   // The memory read missed the write at the same edge and the held write.
   always_comb begin
      if (pend_valid_ff && (pend_addr_ff == s1_col_ff)) begin
         top_pix = pend_data_ff;
      end else if (up_last_en_ff && (up_last_addr_ff == s1_col_ff)) begin
         top_pix = up_last_data_ff;
      end else begin
         top_pix = upper_rd;
      end
   end

   // ---------------------------------------------------------------- window
   // Entries 0..2 hold the column two to the left (top, middle, bottom),
   // entries 3..5 the column just to the left.
   thbs_smooth u_smooth (
      .tl    (win_ff[0]),
      .tc    (win_ff[3]),
      .tr    (top_pix),
      .ml    (win_ff[1]),
      .mc    (win_ff[4]),
      .mr    (middle_rd),
      .bl    (win_ff[2]),
      .bc    (win_ff[5]),
      .br    (s1_pix_ff),
      .limit (change_limit_ff),
      .fin   (fin_pix)
   );

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_in[i] = win_ff[i];
      end
      if (s1_valid_ff) begin
         win_in[0] = win_ff[3];
         win_in[1] = s1_fin_en_ff ? fin_pix : win_ff[4];
         win_in[2] = win_ff[5];
         win_in[3] = top_pix;
         win_in[4] = middle_rd;
         win_in[5] = s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- results
   always_comb begin
      push.second.row  = s1_row_ff;
      push.second.col  = PIX_COL_W'(s1_col_ff);
      push.second.pix  = s1_pix_ff;
      push.second.done = s1_done_ff;
      if (s1_fin_en_ff) begin
         push.first.row  = s1_row_ff - 1'b1;
         push.first.col  = PIX_COL_W'(s1_col_ff - 1'b1);
         push.first.pix  = fin_pix;
         push.first.done = 1'b0;
      end else begin
         push.first = push.second;
      end
      if (s1_valid_ff) begin
         push.count = PUSH_W'(s1_fin_en_ff) + PUSH_W'(s1_border_ff);
      end else begin
         push.count = '0;
      end
   end

   thbs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .level     (fifo_level)
   );

   assign rsp_pixel_row  = rsp_item.row;
   assign rsp_pixel_col  = rsp_item.col;
   assign rsp_red_out    = rsp_item.pix[0];
   assign rsp_green_out  = rsp_item.pix[1];
   assign rsp_blue_out   = rsp_item.pix[2];
   assign rsp_frame_done = rsp_item.done;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (fifo_level + RSP_LEVEL_W'(push.count)) <= RSP_LEVEL_W'(RSP_DEPTH))
      else $error("compute stage pushed into a full response queue");

   assert property (@(posedge clock) disable iff (reset)
      fifo_level <= RSP_LEVEL_W'(RSP_DEPTH))
      else $error("response queue level out of range");

   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |=> !pend_valid_ff)
      else $error("held upper line write not flushed in an idle cycle");

   assert property (@(posedge clock) disable iff (reset)
      up_last_en_ff |-> $past(s1_valid_ff || pend_valid_ff))
      else $error("upper line written with nothing to write");
`endif

endmodule
